// ----- design/bitmask_overlap_collision_unit_macros.svh -----
// Assertion macros for the bitmask overlap collision unit.
`ifndef BITMASK_OVERLAP_COLLISION_UNIT_MACROS_SVH
`define BITMASK_OVERLAP_COLLISION_UNIT_MACROS_SVH

// Assert that a property holds on every rising clock edge outside reset.
`define BOC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that a condition implies another in the next cycle.
`define BOC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- design/boc_pkg.sv -----
package boc_pkg;

  localparam int MaxSize = 64;
  localparam int DimW    = $clog2(MaxSize + 1);
  localparam int IdxW    = $clog2(MaxSize);
  localparam int AddrW   = IdxW + 1;

  typedef enum logic {
    OP_FILL  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_FIRST_WIDTH   = 2'd0,
    REG_FIRST_HEIGHT  = 2'd1,
    REG_SECOND_WIDTH  = 2'd2,
    REG_SECOND_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_Q_ROWS,
    ST_Q_RD,
    ST_Q_CHK,
    ST_DONE
  } state_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic               query;   // 1 query, 0 fill
    logic               hit;     // query: boxes overlap
    logic               write;   // fill: something to write
    logic               mask;
    logic               bit_value;
    logic [IdxW-1:0]    col_lo;  // fill: columns; query: first mask column (mask 0)
    logic [DimW-1:0]    col_n;   // number of columns to visit
    logic [MaxSize-1:0] row_bits;// fill: row mask
    logic [IdxW-1:0]    col1;    // query: first column in mask 1
    logic [IdxW-1:0]    row0;    // query: first row in mask 0
    logic [IdxW-1:0]    row1;    // query: first row in mask 1
    logic [DimW-1:0]    row_n;   // query: rows in overlap
    logic [DimW-1:0]    step;
  } cmd_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [6:0] v);
    clamp_dim = (v > 7'(MaxSize)) ? DimW'(MaxSize) : DimW'(v);
  endfunction

endpackage

// ----- design/boc_ram.sv -----
module boc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/boc_front.sv -----
module boc_front
  import boc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [103:0] in_data,
  input  logic [DimW-1:0] fw0,
  input  logic [DimW-1:0] fh0,
  input  logic [DimW-1:0] fw1,
  input  logic [DimW-1:0] fh1,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);

  // Field unpack.
  logic              op, msel, bval;
  logic signed [6:0] fx, fy;
  logic [6:0]        fwid, fhgt, stp;
  logic signed [15:0] x0, y0, x1, y1;

  assign op   = in_data[0];
  assign msel = in_data[1];
  assign fx   = in_data[8:2];
  assign fy   = in_data[15:9];
  assign fwid = in_data[22:16];
  assign fhgt = in_data[29:23];
  assign bval = in_data[30];
  assign x0   = in_data[46:31];
  assign y0   = in_data[62:47];
  assign x1   = in_data[78:63];
  assign y1   = in_data[94:79];
  assign stp  = in_data[101:95];

  cmd_t cmd;
  logic [DimW-1:0] mw, mh;
  logic [7:0] xe_f, ye_f;
  logic [7:0] xe_c, ye_c;
  logic signed [17:0] xa0, xb0, ya0, yb0, xa1, xb1, ya1, yb1;
  logic signed [17:0] xs, xe, ys, ye;
  logic ovl;

  // Stage register holds the classified item (queue of depth two).
  cmd_t          buf_q [2];
  logic [1:0]    cnt;
  logic          wptr, rptr;

  always_comb begin
    cmd = '0;
    mw  = msel ? fw1 : fw0;
    mh  = msel ? fh1 : fh0;
    xe_f = 8'(fx[5:0]) + 8'(fwid);
    ye_f = 8'(fy[5:0]) + 8'(fhgt);
    xe_c = (xe_f < 8'(mw)) ? xe_f : 8'(mw);
    ye_c = (ye_f < 8'(mh)) ? ye_f : 8'(mh);
    xa0 = 18'(x0); ya0 = 18'(y0); xa1 = 18'(x1); ya1 = 18'(y1);
    xb0 = xa0 + 18'(fw0); yb0 = ya0 + 18'(fh0);
    xb1 = xa1 + 18'(fw1); yb1 = ya1 + 18'(fh1);
    ovl = !(xb0 <= xa1 || yb0 <= ya1 || xa0 >= xb1 || ya0 >= yb1);
    xs = (xa0 < xa1) ? xa1 : xa0;
    ys = (ya0 < ya1) ? ya1 : ya0;
    xe = (xb0 < xb1) ? xb0 : xb1;
    ye = (yb0 < yb1) ? yb0 : yb1;
    cmd.query     = op;
    cmd.mask      = msel;
    cmd.bit_value = bval;
    cmd.step      = (stp == 7'd0) ? DimW'(1) : DimW'(stp);
    if (op == OP_QUERY) begin
      // an empty mask can still pass the box test; nothing is sampled then
      cmd.hit    = ovl && (xe > xs) && (ye > ys);
      cmd.col_lo = IdxW'(xs - xa0);
      cmd.col1   = IdxW'(xs - xa1);
      cmd.row0   = IdxW'(ys - ya0);
      cmd.row1   = IdxW'(ys - ya1);
      cmd.col_n  = DimW'(xe - xs);
      cmd.row_n  = DimW'(ye - ys);
    end else begin
      cmd.write  = !fx[6] && !fy[6] && (8'(fx) < xe_c) && (8'(fy) < ye_c);
      cmd.col_lo = IdxW'(fx[5:0]);
      cmd.col_n  = DimW'(xe_c - 8'(fx[5:0]));
      for (int k = 0; k < MaxSize; k++) begin
        cmd.row_bits[k] = (8'(k) >= 8'(fy[5:0])) && (8'(k) < ye_c);
      end
    end
  end

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = buf_q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; wptr <= 1'b0; rptr <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        wptr <= ~wptr;
      end
      if (q_valid && q_ready) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
    if (in_valid && in_ready) begin
      buf_q[wptr] <= cmd;
    end
  end

  logic unused;
  assign unused = ^in_data[103:102];

endmodule

// ----- design/boc_back.sv -----
module boc_back
  import boc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   q_valid,
  output logic   q_ready,
  input  cmd_t   q_cmd,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   out_collided
);
`include "bitmask_overlap_collision_unit_macros.svh"

  state_t state, state_next;
  cmd_t   cmd, cmd_next;
  logic [DimW-1:0] ci, ci_next;     // column offset walked so far
  logic            res, res_next;
  logic [AddrW-1:0] raddr, waddr;
  logic             we;
  logic [MaxSize-1:0] rdata, wdata;
  logic [AddrW-1:0]  a0_addr;
  logic [MaxSize-1:0] m0_col, m0_col_next;
  logic [MaxSize-1:0] rowsel;
  logic [1:0]         phase, phase_next; // query: 0 read m0, 1 read m1
  logic [MaxSize-1:0] row_pick, row_pick_next; // sampled row offsets
  logic [7:0]         sh, sh_next;             // doubling stride for row_pick

  boc_ram #(.Width(MaxSize), .Depth(2 * MaxSize)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Sampled rows of mask 1 shifted into mask 0 row space is avoided: compare per row.
  always_comb begin
    for (int r = 0; r < MaxSize; r++) begin
      rowsel[r] = 1'b0;
    end
    for (int r = 0; r < MaxSize; r++) begin
      if (DimW'(r) < cmd.row_n && row_pick[r]) begin
        rowsel[r] = m0_col[IdxW'(r + int'(cmd.row0))] &
                    rdata[IdxW'(r + int'(cmd.row1))];
      end
    end
  end

  always_comb begin
    state_next  = state;
    cmd_next    = cmd;
    ci_next     = ci;
    res_next    = res;
    m0_col_next = m0_col;
    phase_next  = phase;
    row_pick_next = row_pick;
    sh_next     = sh;
    q_ready     = 1'b0;
    we          = 1'b0;
    a0_addr     = {1'b0, IdxW'(cmd.col_lo + IdxW'(ci))};
    raddr       = a0_addr;
    waddr       = {cmd.mask, IdxW'(cmd.col_lo + IdxW'(ci))};
    wdata       = (rdata & ~cmd.row_bits) | ({MaxSize{cmd.bit_value}} & cmd.row_bits);
    unique case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_next = q_cmd;
          ci_next  = '0;
          res_next = 1'b0;
          phase_next = '0;
          row_pick_next = MaxSize'(1);
          sh_next  = 8'(q_cmd.step);
          if (q_cmd.query == OP_QUERY) begin
            state_next = q_cmd.hit ? ST_Q_ROWS : ST_DONE;
          end else begin
            state_next = q_cmd.write ? ST_FILL_RD : ST_DONE;
          end
        end
      end
      ST_FILL_RD: begin
        raddr = waddr;
        state_next = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        we = 1'b1;
        ci_next = ci + 1'b1;
        state_next = (ci + 1'b1 >= cmd.col_n) ? ST_DONE : ST_FILL_RD;
      end
      ST_Q_ROWS: begin
        // multiples of the stride: each pass doubles the covered count
        row_pick_next = row_pick | (row_pick << sh);
        sh_next = sh << 1;
        if (sh_next >= 8'(MaxSize)) begin
          state_next = ST_Q_RD;
        end
      end
      ST_Q_RD: begin
        // Issue mask 0 read, then mask 1 read.
        if (phase == 2'd0) begin
          raddr = a0_addr;
          phase_next = 2'd1;
        end else begin
          m0_col_next = rdata;
          raddr = {1'b1, IdxW'(cmd.col1 + IdxW'(ci))};
          state_next = ST_Q_CHK;
        end
      end
      ST_Q_CHK: begin
        phase_next = 2'd0;
        if (|rowsel) begin
          res_next = 1'b1;
          state_next = ST_DONE;
        end else if (({1'b0, ci} + {1'b0, cmd.step}) >= {1'b0, cmd.col_n}) begin
          state_next = ST_DONE;
        end else begin
          ci_next = ci + cmd.step;
          state_next = ST_Q_RD;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid    = (state == ST_DONE);
  assign out_collided = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    cmd    <= cmd_next;
    ci     <= ci_next;
    res    <= res_next;
    m0_col <= m0_col_next;
    phase  <= phase_next;
    row_pick <= row_pick_next;
    sh     <= sh_next;
  end

  `BOC_ASSERT(a_no_write_query, !(we && cmd.query), "write during query")
  `BOC_ASSERT_NEXT(a_fill_result, (state == ST_DONE && !cmd.query), !out_valid || !out_collided,
    "fill returned collision")
  `BOC_ASSERT_NEXT(a_done_hold, (state == ST_DONE && !out_ready), out_valid,
    "result dropped")

endmodule

// ----- design/bitmask_overlap_collision_unit.sv -----
// Pixel-perfect collision of two opacity masks (up to 64x64 each). Fill items
// write a bit into a clipped rectangle of one mask; query items place both masks
// at signed world positions and test a stride-sampled overlap for a shared opaque
// pixel. One result per item. A front stage classifies each item and computes the
// clipped extents, and hands it through a two-entry queue to a back sequencer.
// The sequencer takes one item at a time. An item is registered in the queue on
// its transfer; the sequencer takes it while idle and presents the result until
// it is taken. A fill reads and then writes each column in turn. An overlapping
// query builds its sampled-row pattern, one pass per doubling of the stride below
// 64, then reads mask 0 and mask 1 per sampled column (one RAM read port) and checks.
// Mask memory is undefined after reset; fill before querying.
// s_axis_tdata, low bit up: operation, mask_select, fill_x, fill_y, fill_width,
// fill_height, bit_value, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
// sample_step, zero pad to 104 bits. m_axis_tdata: collided, zero pad.
module bitmask_overlap_collision_unit
  import boc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // fields as listed above
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,  // collided, pad
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data
);

  logic [6:0] first_width, first_height, second_width, second_height;
  logic       q_valid, q_ready, collided;
  cmd_t       q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_width <= '0; first_height <= '0; second_width <= '0; second_height <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FIRST_WIDTH:   first_width   <= cfg_data;
        REG_FIRST_HEIGHT:  first_height  <= cfg_data;
        REG_SECOND_WIDTH:  second_width  <= cfg_data;
        REG_SECOND_HEIGHT: second_height <= cfg_data;
        default: ;
      endcase
    end
  end

  boc_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .fw0(clamp_dim(first_width)), .fh0(clamp_dim(first_height)),
    .fw1(clamp_dim(second_width)), .fh1(clamp_dim(second_height)),
    .q_valid, .q_ready, .q_cmd
  );

  // back sequencer: walks the mask RAM, one result per item
  boc_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_collided(collided)
  );

  assign m_axis_tdata = {7'd0, collided};

endmodule

// ----- tb/bitmask_overlap_collision_checker.sv -----
module bitmask_overlap_collision_checker
  import boc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [7:0]   m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data,
  output int           errors,
  output int           pending
);

  bit [MaxSize-1:0] col_bits [0:2*MaxSize-1];
  bit [6:0]         dim_w [0:1];
  bit [6:0]         dim_h [0:1];
  bit               collide_q [$];

  function automatic int clip_dim(bit [6:0] v);
    return (v > MaxSize) ? MaxSize : int'(v);
  endfunction

  function automatic bit opaque(int m, int col, int row);
    if (col < 0 || row < 0 || col >= MaxSize || row >= MaxSize) return 1'b0;
    return col_bits[m*MaxSize + col][row];
  endfunction

  task automatic paint_rect(bit m, int fx, int fy, int fw, int fh, bit b);
    int xe, ye;
    if (fx < 0 || fy < 0) return;
    xe = (fx + fw < clip_dim(dim_w[m])) ? fx + fw : clip_dim(dim_w[m]);
    ye = (fy + fh < clip_dim(dim_h[m])) ? fy + fh : clip_dim(dim_h[m]);
    for (int i = fx; i < xe; i++)
      for (int k = fy; k < ye; k++)
        col_bits[int'(m)*MaxSize + i][k] = b;
  endtask

  function automatic bit overlap_hit(int x, int y, int x2, int y2, int st);
    int w, h, w2, h2, xs, xe, ys, ye;
    w  = clip_dim(dim_w[0]);
    h  = clip_dim(dim_h[0]);
    w2 = clip_dim(dim_w[1]);
    h2 = clip_dim(dim_h[1]);
    if (st == 0) st = 1;
    if (x + w <= x2 || y + h <= y2 || x >= x2 + w2 || y >= y2 + h2) return 1'b0;
    xs = (x < x2) ? x2 : x;
    ys = (y < y2) ? y2 : y;
    xe = (x + w < x2 + w2) ? x + w : x2 + w2;
    ye = (y + h < y2 + h2) ? y + h : y2 + h2;
    for (int b = ys; b < ye; b += st)
      for (int a = xs; a < xe; a += st)
        if (opaque(0, a - x, b - y) && opaque(1, a - x2, b - y2)) return 1'b1;
    return 1'b0;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
    foreach (col_bits[i]) col_bits[i] = '0;
    dim_w = '{7'd0, 7'd0};
    dim_h = '{7'd0, 7'd0};
  end

  always @(posedge clk) begin
    bit want;
    if (!rst) begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_FIRST_WIDTH:   dim_w[0] = cfg_data;
          REG_FIRST_HEIGHT:  dim_h[0] = cfg_data;
          REG_SECOND_WIDTH:  dim_w[1] = cfg_data;
          REG_SECOND_HEIGHT: dim_h[1] = cfg_data;
          default: ;
        endcase
      end
      // result side first: it always belongs to an older item
      if (m_axis_tvalid && m_axis_tready) begin
        if (collide_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, m_axis_tdata);
          errors++;
        end else begin
          want = collide_q.pop_front();
          if (m_axis_tdata !== {7'd0, want}) begin
            $display("%0t: collided mismatch, expected %0d, actual %0d",
                     $time, {7'd0, want}, m_axis_tdata);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (op_t'(s_axis_tdata[0]) == OP_QUERY) begin
          collide_q.push_back(overlap_hit(int'($signed(s_axis_tdata[46:31])),
                                          int'($signed(s_axis_tdata[62:47])),
                                          int'($signed(s_axis_tdata[78:63])),
                                          int'($signed(s_axis_tdata[94:79])),
                                          int'(s_axis_tdata[101:95])));
        end else begin
          paint_rect(s_axis_tdata[1], int'($signed(s_axis_tdata[8:2])),
                     int'($signed(s_axis_tdata[15:9])), int'(s_axis_tdata[22:16]),
                     int'(s_axis_tdata[29:23]), s_axis_tdata[30]);
          collide_q.push_back(1'b0);
        end
      end
      pending = collide_q.size();
    end
  end

endmodule

// ----- tb/tb_bitmask_overlap_collision_unit.sv -----
module tb_bitmask_overlap_collision_unit;
  import boc_pkg::*;

  localparam int StallLimit = 40000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;  // op, mask, fill x/y/w/h, bit, pos x/y x2, step, pad
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;       // collided, pad
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [6:0]   cfg_data = '0;

  int errors, pending;
  int sent;
  int send_gap_pct, take_gap_pct;
  int stall_cnt;
  bit held_off;

  bitmask_overlap_collision_unit dut (.*);

  bitmask_overlap_collision_checker chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: cycles with no transfer on either stream
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cnt <= 0;
    else if (stall_cnt >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      stall_cnt <= stall_cnt + 1;
  end

  // Receiver: random back-pressure, plus one long hold-off so the queue fills
  initial begin
    @(negedge clk);
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!held_off && sent >= 60) begin
        held_off = 1'b1;
        repeat (600) begin
          m_axis_tready <= 1'b0;
          @(negedge clk);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // Sender: called and returns at a falling edge
  task automatic push_item(bit [103:0] d);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    sent++;
    // pick the idle mix by progress through the run
    if (sent < 620) begin
      send_gap_pct = 9;  take_gap_pct = 48;
    end else if (sent < 1240) begin
      send_gap_pct = 48; take_gap_pct = 9;
    end else begin
      send_gap_pct = 0;  take_gap_pct = 0;
    end
  endtask

  task automatic fill_rect(bit m, bit [6:0] x, bit [6:0] y, bit [6:0] w, bit [6:0] h, bit b);
    push_item({2'b0, 7'd1, 64'd0, b, h, w, y, x, m, OP_FILL});
  endtask

  task automatic query_pos(bit [15:0] x, bit [15:0] y, bit [15:0] x2, bit [15:0] y2,
                           bit [6:0] st);
    push_item({2'b0, st, y2, x2, y, x, 1'b0, 28'd0, 1'b0, OP_QUERY});
  endtask

  task automatic write_reg(reg_idx_t idx, bit [6:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Drain, then set the mask sizes and cover every pixel of both masks
  task automatic new_sizes(bit [6:0] w0, bit [6:0] h0, bit [6:0] w1, bit [6:0] h1);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
    write_reg(REG_FIRST_WIDTH, w0);
    write_reg(REG_FIRST_HEIGHT, h0);
    write_reg(REG_SECOND_WIDTH, w1);
    write_reg(REG_SECOND_HEIGHT, h1);
    fill_rect(1'b0, 7'd0, 7'd0, 7'd64, 7'd64, 1'($urandom_range(1)));
    fill_rect(1'b1, 7'd0, 7'd0, 7'd64, 7'd64, 1'($urandom_range(1)));
  endtask

  task automatic random_items(int n);
    bit [15:0] base_x, base_y;
    bit [6:0]  st;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 40) begin
        // mostly in-range origins, sometimes negative ones
        fill_rect(1'($urandom_range(1)),
                  ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(63)),
                  ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(63)),
                  ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(24)),
                  ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(24)),
                  1'($urandom_range(1)));
      end else begin
        base_x = 16'($urandom);
        base_y = 16'($urandom);
        st = ($urandom_range(5) == 0) ? 7'($urandom) : 7'($urandom_range(4));
        if ($urandom_range(9) == 0)
          query_pos(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), st);
        else
          query_pos(base_x + 16'($urandom_range(80)) - 16'd40,
                    base_y + 16'($urandom_range(80)) - 16'd40,
                    base_x, base_y, st);
      end
    end
  endtask

  initial begin
    send_gap_pct = 9;
    take_gap_pct = 48;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: full masks, clipping, negative origin, strides, far corners
    new_sizes(7'd64, 7'd64, 7'd64, 7'd64);
    fill_rect(1'b0, 7'd0, 7'd0, 7'd64, 7'd64, 1'b1);
    fill_rect(1'b1, 7'd0, 7'd0, 7'd64, 7'd64, 1'b0);
    fill_rect(1'b1, 7'd63, 7'd63, 7'd64, 7'd64, 1'b1);
    fill_rect(1'b1, 7'h7F, 7'd0, 7'd64, 7'd64, 1'b1);
    fill_rect(1'b1, 7'd0, 7'h40, 7'd64, 7'd64, 1'b1);
    query_pos(16'd0, 16'd0, 16'd0, 16'd0, 7'd1);
    query_pos(16'd0, 16'd0, 16'd0, 16'd0, 7'd0);
    query_pos(16'd0, 16'd0, 16'd0, 16'd0, 7'd127);
    query_pos(16'd0, 16'd0, 16'd0, 16'd0, 7'd63);
    query_pos(16'd0, 16'd0, 16'd64, 16'd0, 7'd1);
    query_pos(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 7'd1);
    query_pos(16'h7FFF, 16'h7FFF, 16'h7FC1, 16'h7FC1, 7'd1);
    query_pos(16'hFFC1, 16'hFFC1, 16'd0, 16'd0, 7'd1);
    fill_rect(1'b1, 7'd10, 7'd20, 7'd0, 7'd5, 1'b1);
    fill_rect(1'b0, 7'd30, 7'd30, 7'd4, 7'd0, 1'b0);
    fill_rect(1'b1, 7'd5, 7'd5, 7'd1, 7'd1, 1'b1);
    query_pos(16'd0, 16'd0, 16'd0, 16'd0, 7'd5);
    query_pos(16'd0, 16'd0, 16'd0, 16'd0, 7'd2);
    random_items(180);

    new_sizes(7'd1, 7'd1, 7'd1, 7'd1);
    random_items(200);
    new_sizes(7'd0, 7'd64, 7'd64, 7'd0);  // empty masks never collide
    random_items(150);
    new_sizes(7'd127, 7'd127, 7'd127, 7'd127);  // oversized, clamped
    random_items(230);
    new_sizes(7'd64, 7'd1, 7'd1, 7'd64);
    random_items(200);
    for (int p = 0; p < 4; p++) begin
      new_sizes(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
      random_items(200);
    end
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (200) @(negedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
